// ===== design/ufc_pkg.sv =====
`default_nettype none

package ufc_pkg;

  localparam int unsigned NodeIdW   = 8;
  localparam int unsigned CaseW     = 16;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 24;

  // Item kind carried on tuser
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [CaseW-1:0] case_number;
    logic             is_tree;
  } ufc_res_t;

endpackage

`default_nettype wire

// ===== design/ufc_ram.sv =====
`default_nettype none

module ufc_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/ufc_engine.sv =====
`default_nettype none

module ufc_engine
  import ufc_pkg::*;
#(
  parameter int unsigned Nodes = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [NodeIdW-1:0] node_a_i,
  input  wire logic [NodeIdW-1:0] node_b_i,
  output ufc_res_t                res_o,
  input  wire logic               res_ready_i,
  output logic                    mem_we_o,
  output logic [$clog2(Nodes)-1:0] mem_waddr_o,
  output logic [$clog2(Nodes):0]  mem_wdata_o,
  output logic                    mem_re_o,
  output logic [$clog2(Nodes)-1:0] mem_raddr_o,
  input  wire logic [$clog2(Nodes):0] mem_rdata_i
);

  localparam int unsigned IW = $clog2(Nodes);
  localparam int unsigned CW = IW + 1;

  typedef enum logic [2:0] {
    S_SCAN, S_IDLE, S_FIND_A, S_START_B, S_FIND_B, S_LINK, S_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [IW-1:0]      a_q, a_d, b_q, b_d, cur_q, cur_d, ra_q, ra_d, rb_q, rb_d;
  logic [IW-1:0]      pidx_q, pidx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               pend_q, pend_d, emit_q, emit_d;
  logic               still_q, still_d, seen_q, seen_d, multi_q, multi_d;
  logic               verdict_q, verdict_d;
  logic [CaseW-1:0]   case_q, case_d;

  logic               r_used;
  logic [IW-1:0]      r_par;
  logic               a_ok, b_ok;

  assign r_used = mem_rdata_i[IW];
  assign r_par  = mem_rdata_i[IW-1:0];
  assign a_ok   = (node_a_i != '0) && (32'(node_a_i) < 32'(Nodes));
  assign b_ok   = (node_b_i != '0) && (32'(node_b_i) < 32'(Nodes));

  assign res_o.valid       = (state_q == S_EMIT);
  assign res_o.case_number = case_q;
  assign res_o.is_tree     = verdict_q;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    pidx_d      = pidx_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    emit_d      = emit_q;
    still_d     = still_q;
    seen_d      = seen_q;
    multi_d     = multi_q;
    verdict_d   = verdict_q;
    case_d      = case_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i == KIND_END) begin
            state_d = S_SCAN;
            cnt_d   = '0;
            pend_d  = 1'b0;
            emit_d  = 1'b1;
            seen_d  = 1'b0;
            multi_d = 1'b0;
          end else if (!(a_ok && b_ok)) begin
            still_d = 1'b0;
          end else begin
            a_d         = IW'(node_a_i);
            b_d         = IW'(node_b_i);
            cur_d       = IW'(node_a_i);
            mem_re_o    = 1'b1;
            mem_raddr_o = IW'(node_a_i);
            state_d     = S_FIND_A;
          end
        end
      end

      S_FIND_A: begin
        if (r_par == cur_q) begin
          // root reached: mark used and point the start straight at the root
          mem_we_o    = 1'b1;
          mem_waddr_o = a_q;
          mem_wdata_o = {1'b1, cur_q};
          ra_d        = cur_q;
          state_d     = S_START_B;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = r_par;
          cur_d       = r_par;
        end
      end

      S_START_B: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = b_q;
        cur_d       = b_q;
        state_d     = S_FIND_B;
      end

      S_FIND_B: begin
        if (r_par == cur_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = b_q;
          mem_wdata_o = {1'b1, cur_q};
          rb_d        = cur_q;
          if (cur_q == ra_q) begin
            still_d = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_LINK;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = r_par;
          cur_d       = r_par;
        end
      end

      S_LINK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = rb_q;
        mem_wdata_o = {1'b1, ra_q};
        state_d     = S_IDLE;
      end

      S_SCAN: begin
        if (pend_q) begin
          // count roots among used nodes, then reset the entry
          if (r_used && (r_par == pidx_q)) begin
            if (seen_q) begin
              multi_d = 1'b1;
            end
            seen_d = 1'b1;
          end
          mem_we_o    = 1'b1;
          mem_waddr_o = pidx_q;
          mem_wdata_o = {1'b0, pidx_q};
        end
        if (cnt_q != CW'(Nodes)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cnt_q[IW-1:0];
          pidx_d      = cnt_q[IW-1:0];
          pend_d      = 1'b1;
          cnt_d       = cnt_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            verdict_d = still_q && !multi_q;
            still_d   = 1'b1;
            state_d   = emit_q ? S_EMIT : S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (res_ready_i) begin
          case_d  = case_q + CaseW'(1);
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SCAN;
      a_q       <= '0;
      b_q       <= '0;
      cur_q     <= '0;
      ra_q      <= '0;
      rb_q      <= '0;
      pidx_q    <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      emit_q    <= 1'b0;
      still_q   <= 1'b1;
      seen_q    <= 1'b0;
      multi_q   <= 1'b0;
      verdict_q <= 1'b0;
      case_q    <= CaseW'(1);
    end else begin
      state_q   <= state_d;
      a_q       <= a_d;
      b_q       <= b_d;
      cur_q     <= cur_d;
      ra_q      <= ra_d;
      rb_q      <= rb_d;
      pidx_q    <= pidx_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      emit_q    <= emit_d;
      still_q   <= still_d;
      seen_q    <= seen_d;
      multi_q   <= multi_d;
      verdict_q <= verdict_d;
      case_q    <= case_d;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o)))
    else $error("read and write hit the same entry in one cycle");

  a_link_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> (ra_q != rb_q))
    else $error("link attempted between equal roots");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= CW'(Nodes)))
    else $error("scan counter ran past the table");

  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_ready_i) |=> (case_q == $past(case_q) + CaseW'(1)))
    else $error("case count did not advance on result hand-off");
`endif

endmodule

`default_nettype wire

// ===== design/union_find_tree_check_core.sv =====
`default_nettype none
// Edge: node_a's chain and then node_b's chain are walked, one parent-table read per hop
//   on the single read port, then the two roots are linked; a cycle-closing edge skips the link.
// End of case: a scan-and-clear pass over the parent table, then the result is handed over.
// Throughput: one item at a time; a finished result waits in the output register.
// Reset: asynchronous, active low; a clearing pass over the parent table follows reset,
//   during which s_axis_tready stays low.

module union_find_tree_check_core
  import ufc_pkg::*;
#(
  parameter int unsigned NODES = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // node_a [7:0], node_b [15:8]
  input  wire logic [0:0]          s_axis_tuser,   // kind [0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata    // case_number [15:0], is_tree [16], zero pad
);

  localparam int unsigned IW = $clog2(NODES);

  ufc_res_t          res;
  logic              res_ready;
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [IW:0]       mem_wdata, mem_rdata;

  logic              out_valid_q;
  logic [CaseW-1:0]  out_case_q;
  logic              out_tree_q;

  // Parent table: each entry is {used, parent}
  ufc_ram #(
    .Depth (NODES),
    .Width (IW + 1)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ufc_engine #(
    .Nodes (NODES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser[0]),
    .node_a_i    (s_axis_tdata[7:0]),
    .node_b_i    (s_axis_tdata[15:8]),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Accept a new result when the output register is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  // Payload needs no reset; hold it while the transaction stalls
  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_case_q <= res.case_number;
      out_tree_q <= res.is_tree;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - CaseW - 1){1'b0}}, out_tree_q, out_case_q};

endmodule

`default_nettype wire
